/* hw/rtl/ede_pkg.sv */
// Package: shared constants and transaction types for the edit distance engine.
`timescale 1ns / 1ps
`default_nettype none

package ede_pkg;

   localparam int MAX_LEN  = 64;
   localparam int LEN_W    = $clog2(MAX_LEN + 1);
   localparam int ADDR_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CHAR_W   = 8;
   localparam int DIST_W   = 7;
   localparam int DIST_MAX = (1 << DIST_W) - 1;

   localparam logic OP_FIRST  = 1'b0;
   localparam logic OP_SECOND = 1'b1;

   typedef struct packed {
      logic              operation;
      logic [CHAR_W-1:0] character;
      logic              has_char;
      logic              last;
   } req_payload_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              overflow;
   } rsp_payload_type;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SWEEP  = 4'b0010,
      S_FETCH  = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

endpackage : ede_pkg

`default_nettype wire

/* hw/rtl/ede_cell.sv */
// One Levenshtein cell: copy the diagonal on a match, else one plus the smallest neighbor.
`timescale 1ns / 1ps
`default_nettype none

module ede_cell (
   input  wire logic [ede_pkg::CHAR_W-1:0] first_char,
   input  wire logic [ede_pkg::CHAR_W-1:0] second_char,
   input  wire logic [ede_pkg::LEN_W-1:0]  left,
   input  wire logic [ede_pkg::LEN_W-1:0]  above,
   input  wire logic [ede_pkg::LEN_W-1:0]  diag,
   output      logic [ede_pkg::LEN_W-1:0]  cost
);
   import ede_pkg::*;

   logic [LEN_W-1:0] best_lu;
   logic [LEN_W-1:0] best;

   always_comb begin
      best_lu = (above < left) ? above : left;
      best    = (diag < best_lu) ? diag : best_lu;
      if (first_char == second_char) begin
         cost = diag;
      end else begin
         cost = best + LEN_W'(1);
      end
   end

endmodule : ede_cell

`default_nettype wire

/* hw/rtl/edit_distance_engine_core.sv */
// Top level: Levenshtein edit distance engine with memory-held string and distance row.
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake            | Transaction
// --------+-----------+----------------------+------------------------------------------
// req     | in        | req_valid/req_ready  | one character of the first or second string
// rsp     | out       | rsp_valid/rsp_ready  | edit distance and overflow flag
//
// A first-string transaction is handled in its accept cycle. A second-string character, for a
// stored first-string length L of 1..64, sweeps the row: the accept cycle issues the first read,
// then one cell per cycle, then a row-closing step. With L = 0 or past MAX_LEN there is no sweep.
// The transaction that ends the second string then passes through fetch, then register the result.
// Reset is synchronous and active high; neither memory needs clearing.
// A result held on rsp_ready stalls the next result state, and with it the input.

module edit_distance_engine_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output      logic                     req_ready,
   input  wire ede_pkg::req_payload_type req_payload,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      ede_pkg::rsp_payload_type rsp_payload
);
   import ede_pkg::*;

   // Stores: first string and distance row cells 1..MAX_LEN (cell 0 is count_ff).
   logic [CHAR_W-1:0] fs_mem [MAX_LEN];
   logic [LEN_W-1:0]  dp_mem [MAX_LEN];
   logic [CHAR_W-1:0] fs_rd_ff;
   logic [LEN_W-1:0]  dp_rd_ff;

   state_type         state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic              second_ff, second_in;
   logic              ovf_ff, ovf_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] cell_k_ff, cell_k_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [LEN_W-1:0]  diag_ff, diag_in;
   logic [CHAR_W-1:0] ch_ff, ch_in;
   logic              last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_ff, rsp_in;

   logic              accept;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              fs_we;
   logic              dp_we;
   logic [LEN_W-1:0]  next_k;
   logic [LEN_W-1:0]  above;
   logic [LEN_W-1:0]  cell_cost;
   logic [LEN_W-1:0]  dist_full;
   logic [31:0]       dist_wide;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign next_k = LEN_W'(cell_k_ff) + LEN_W'(1);
   // A fresh row (no second-string character yet) holds cell index i at position i.
   assign above  = (count_ff == '0) ? next_k : dp_rd_ff;

   ede_cell u_cell (
      .first_char  (fs_rd_ff),
      .second_char (ch_ff),
      .left        (left_ff),
      .above       (above),
      .diag        (diag_ff),
      .cost        (cell_cost)
   );

   // Distance: cell 0 is the count, a fresh row gives the length, else read the memory.
   always_comb begin
      if (len_ff == '0) begin
         dist_full = count_ff;
      end else if (count_ff == '0) begin
         dist_full = len_ff;
      end else begin
         dist_full = dp_rd_ff;
      end
      dist_wide = 32'(dist_full);
   end

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      second_in    = second_ff;
      ovf_in       = ovf_ff;
      pend_in      = pend_ff;
      cell_k_in    = cell_k_ff;
      left_in      = left_ff;
      diag_in      = diag_ff;
      ch_in        = ch_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      fs_we        = 1'b0;
      dp_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            // Drop transactions of the wrong phase.
            if (accept && (req_payload.operation == second_ff)) begin
               if (!second_ff) begin
                  if (req_payload.has_char) begin
                     if (len_ff < LEN_W'(MAX_LEN)) begin
                        fs_we  = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  if (req_payload.last) begin
                     second_in = 1'b1;
                     count_in  = '0;
                  end
               end else begin
                  ch_in   = req_payload.character;
                  last_in = req_payload.last;
                  if (req_payload.has_char && (count_ff >= LEN_W'(MAX_LEN))) begin
                     ovf_in = 1'b1;
                     if (req_payload.last) begin
                        state_in = S_FETCH;
                     end
                  end else if (req_payload.has_char && (len_ff != '0)) begin
                     // Start the row sweep: issue the read of cell 1.
                     rd_en     = 1'b1;
                     rd_addr   = '0;
                     pend_in   = 1'b1;
                     cell_k_in = '0;
                     diag_in   = count_ff;
                     left_in   = count_ff + LEN_W'(1);
                     state_in  = S_SWEEP;
                  end else begin
                     if (req_payload.has_char) begin
                        count_in = count_ff + LEN_W'(1);
                     end
                     if (req_payload.last) begin
                        state_in = S_FETCH;
                     end
                  end
               end
            end
         end

         S_SWEEP: begin
            if (pend_ff) begin
               dp_we   = 1'b1;
               left_in = cell_cost;
               diag_in = above;
               if (next_k < len_ff) begin
                  rd_en     = 1'b1;
                  rd_addr   = next_k[ADDR_W-1:0];
                  cell_k_in = next_k[ADDR_W-1:0];
               end else begin
                  pend_in = 1'b0;
               end
            end else begin
               count_in = count_ff + LEN_W'(1);
               state_in = last_ff ? S_FETCH : S_IDLE;
            end
         end

         S_FETCH: begin
            rd_en    = 1'b1;
            rd_addr  = ADDR_W'(len_ff - LEN_W'(1));
            state_in = S_RESULT;
         end

         S_RESULT: begin
            // Hold until the output register is free, then advance.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in     = 1'b1;
               rsp_in.distance  = (dist_wide > 32'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                              : DIST_W'(dist_wide);
               rsp_in.overflow  = ovf_ff;
               len_in    = '0;
               count_in  = '0;
               second_in = 1'b0;
               ovf_in    = 1'b0;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memories: one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (fs_we) begin
         fs_mem[len_ff[ADDR_W-1:0]] <= req_payload.character;
      end
      if (rd_en) begin
         fs_rd_ff <= fs_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_we) begin
         dp_mem[cell_k_ff] <= cell_cost;
      end
      if (rd_en) begin
         dp_rd_ff <= dp_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         len_ff       <= '0;
         count_ff     <= '0;
         second_ff    <= 1'b0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         count_ff     <= count_in;
         second_ff    <= second_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cell_k_ff <= cell_k_in;
      left_ff   <= left_in;
      diag_ff   <= diag_in;
      ch_ff     <= ch_in;
      last_ff   <= last_in;
      rsp_ff    <= rsp_in;
   end

endmodule : edit_distance_engine_core

`default_nettype wire

/* tb/edit_distance_engine_core_tb.sv */
// Testbench for the edit distance engine: random string pairs against a row-sweep predictor.
`timescale 1ns / 1ps

module edit_distance_engine_core_tb;
   import ede_pkg::*;

   localparam int ITEM_TARGET    = 1550;  // meaningful request transactions to queue
   localparam int TAIL_ITEMS     = 150;   // final stretch with no idling on either side
   localparam int LONG_HOLD      = 400;   // one long receiver hold-off, in cycles
   localparam int DRAIN_CYCLES   = 150;   // > one full-length sweep plus result fetch
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either channel
   localparam int TEXT_DEPTH     = 80;    // room for strings a little past MAX_LEN

   logic            clock       = 1'b0;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready   = 1'b0;
   rsp_payload_type rsp_payload;

   edit_distance_engine_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------------------
   // Predictor: stored first string, one DP row, and the phase/overflow flags.
   // ---------------------------------------------------------------------------------------
   logic [CHAR_W-1:0] stored_chars [0:MAX_LEN-1];
   int                row_cost [0:MAX_LEN];
   int                stored_len = 0;
   int                second_len = 0;
   logic              phase_op   = OP_FIRST;
   logic              truncated  = 1'b0;
   rsp_payload_type   distance_expected [$];

   // Advance the predictor by one accepted request transaction; queue a distance when the
   // second string ends.
   task automatic track_request(input req_payload_type req);
      int              diag;
      int              above;
      int              new_cost;
      int              best;
      int              dist_sat;
      rsp_payload_type rsp;
      // Drop transactions of the wrong phase: no state change, no result.
      if (req.operation != phase_op) return;
      if (phase_op == OP_FIRST) begin
         if (req.has_char) begin
            if (stored_len < MAX_LEN) begin
               stored_chars[stored_len] = req.character;
               stored_len++;
            end else begin
               truncated = 1'b1;
            end
         end
         if (req.last) begin
            // Seed the row with pure deletion costs.
            for (int i = 0; i <= stored_len; i++) row_cost[i] = i;
            second_len = 0;
            phase_op   = OP_SECOND;
         end
      end else begin
         if (req.has_char) begin
            if (second_len < MAX_LEN) begin
               diag        = row_cost[0];
               row_cost[0] = second_len + 1;
               for (int i = 1; i <= stored_len; i++) begin
                  above = row_cost[i];
                  if (stored_chars[i-1] == req.character) begin
                     new_cost = diag;
                  end else begin
                     best = row_cost[i-1];
                     if (above < best) best = above;
                     if (diag < best) best = diag;
                     new_cost = best + 1;
                  end
                  row_cost[i] = new_cost;
                  diag        = above;
               end
               second_len++;
            end else begin
               truncated = 1'b1;
            end
         end
         if (req.last) begin
            dist_sat = (row_cost[stored_len] > DIST_MAX) ? DIST_MAX : row_cost[stored_len];
            rsp.distance = dist_sat[DIST_W-1:0];
            rsp.overflow = truncated;
            distance_expected.push_back(rsp);
            stored_len = 0;
            second_len = 0;
            phase_op   = OP_FIRST;
            truncated  = 1'b0;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus store: the initial block fills it, the driver drains it.
   // ---------------------------------------------------------------------------------------
   req_payload_type   pending_items [$];
   int                noise_items = 0;
   logic [CHAR_W-1:0] text_buf [0:1][0:TEXT_DEPTH-1];

   task automatic push_item(input logic op, input logic [CHAR_W-1:0] ch, input logic has,
                            input logic last, input bit noise);
      req_payload_type item;
      item.operation = op;
      item.character = ch;
      item.has_char  = has;
      item.last      = last;
      pending_items.push_back(item);
      if (noise) noise_items++;
   endtask

   // Queue one string from text_buf[op]. End it on its last character, or with a separate
   // characterless item; an empty string always ends that way. Optionally sprinkle in
   // wrong-phase transactions and characterless no-ops.
   task automatic queue_string(input logic op, input int len, input bit separate_end,
                               input bit noisy);
      for (int k = 0; k < len; k++) begin
         if (noisy && $urandom_range(0, 19) == 0) begin
            if ($urandom_range(0, 1))
               push_item(!op, CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 1'b1);
            else
               push_item(op, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b1);
         end
         push_item(op, text_buf[op][k], 1'b1, (k == len - 1) && !separate_end, 1'b0);
      end
      if (len == 0 || separate_end)
         push_item(op, CHAR_W'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0);
   endtask

   task automatic fill_text(input int which, input int len, input int base, input int span);
      for (int k = 0; k < len; k++)
         text_buf[which][k] = CHAR_W'(base + $urandom_range(0, span));
   endtask

   // Queue a full first/second string pair. Narrow alphabets and near copies make matches
   // common so that the diagonal path of the sweep gets real use.
   task automatic queue_pair(input int len_a, input int len_b);
      int base;
      int span;
      int shift;
      base  = $urandom_range(0, 255);
      span  = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 3);
      shift = $urandom_range(0, 1);
      fill_text(0, len_a, base, span);
      fill_text(1, len_b, base, span);
      if ($urandom_range(0, 1)) begin
         for (int k = 0; k < len_b && k + shift < len_a; k++)
            if ($urandom_range(0, 4) != 0) text_buf[1][k] = text_buf[0][k + shift];
      end
      queue_string(OP_FIRST, len_a, $urandom_range(0, 3) == 0, 1'b1);
      queue_string(OP_SECOND, len_b, $urandom_range(0, 3) == 0, 1'b1);
   endtask

   // Mostly short strings; a few lie near or past MAX_LEN to hit truncation.
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return 0;
      if (r < 90) return $urandom_range(1, 10);
      if (r < 98) return $urandom_range(11, 40);
      return $urandom_range(MAX_LEN - 2, MAX_LEN + 6);
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: offer pending_items[0], hold it until accepted, idle in short bursts.
   // ---------------------------------------------------------------------------------------
   int   send_gap       = 0;
   int   accepted_items = 0;
   logic quiet_tail     = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  = 0;
      end else begin
         // Feed the accepted transaction to the predictor and retire it.
         if (req_valid && req_ready) begin
            track_request(pending_items.pop_front());
            accepted_items++;
         end
         quiet_tail <= (pending_items.size() <= TAIL_ITEMS);
         // Hold valid and payload steady while a transaction is still waiting.
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_items.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
               send_gap  = $urandom_range(0, 2);
               req_valid <= 1'b0;
            end else begin
               req_valid   <= 1'b1;
               req_payload <= pending_items[0];
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: check each result transaction against the oldest expected distance, and
   // drive rsp_ready with short stalls plus one long hold-off.
   // ---------------------------------------------------------------------------------------
   int              error_count      = 0;
   int              results_checked  = 0;
   int              overflow_results = 0;
   int              hold_left        = 0;
   bit              long_hold_done   = 1'b0;
   rsp_payload_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (distance_expected.size() == 0) begin
               $display({"%0t: unexpected result: expected none, ",
                         "actual distance %0d overflow %0b"},
                        $time, rsp_payload.distance, rsp_payload.overflow);
               error_count++;
            end else begin
               want = distance_expected.pop_front();
               if (rsp_payload.distance !== want.distance) begin
                  $display("%0t: distance mismatch: expected %0d actual %0d",
                           $time, want.distance, rsp_payload.distance);
                  error_count++;
               end
               if (rsp_payload.overflow !== want.overflow) begin
                  $display("%0t: overflow mismatch: expected %0b actual %0b",
                           $time, want.overflow, rsp_payload.overflow);
                  error_count++;
               end
               results_checked++;
               if (want.overflow) overflow_results++;
            end
         end
         // Stall the result side; once, hold off long enough that the engine backs up
         // into its input while the driver keeps offering.
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && results_checked == 6) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            rsp_ready      <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog: end the run if neither channel moves a transaction for too long.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("FAIL edit_distance_engine_core");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sequence: directed cases, boundary pairs, random pairs, then drain and report.
   // ---------------------------------------------------------------------------------------
   initial begin
      int la;
      int lb;

      // Wrong phase while loading the first string, then a characterless no-op.
      push_item(OP_SECOND, 8'hAA, 1'b1, 1'b1, 1'b1);
      push_item(OP_FIRST, 8'h00, 1'b0, 1'b0, 1'b1);
      // Empty first string, a wrong-phase item, empty second string: distance 0.
      push_item(OP_FIRST, 8'hFF, 1'b0, 1'b1, 1'b0);
      push_item(OP_FIRST, 8'h00, 1'b1, 1'b1, 1'b1);
      push_item(OP_SECOND, 8'h55, 1'b0, 1'b1, 1'b0);
      // Extreme characters, swapped: distance 2.
      text_buf[0][0] = 8'h00;
      text_buf[0][1] = 8'hFF;
      text_buf[1][0] = 8'hFF;
      text_buf[1][1] = 8'h00;
      queue_string(OP_FIRST, 2, 1'b0, 1'b0);
      queue_string(OP_SECOND, 2, 1'b1, 1'b0);
      // Empty first against two characters: two insertions.
      text_buf[1][0] = "a";
      text_buf[1][1] = "b";
      queue_string(OP_FIRST, 0, 1'b0, 1'b0);
      queue_string(OP_SECOND, 2, 1'b0, 1'b0);
      // One substitution and one insertion.
      text_buf[0][0] = "a";
      text_buf[0][1] = "b";
      text_buf[0][2] = "c";
      text_buf[1][0] = "a";
      text_buf[1][1] = "x";
      text_buf[1][2] = "c";
      text_buf[1][3] = "d";
      queue_string(OP_FIRST, 3, 1'b1, 1'b0);
      queue_string(OP_SECOND, 4, 1'b0, 1'b0);

      // Full-length strings, then truncation on either side and both.
      queue_pair(MAX_LEN, MAX_LEN);
      queue_pair(MAX_LEN + 2, MAX_LEN + 6);
      queue_pair(0, MAX_LEN + 1);
      queue_pair(MAX_LEN + 1, 0);

      while (pending_items.size() - noise_items < ITEM_TARGET) begin
         la = pick_len();
         if ($urandom_range(0, 1)) lb = la + $urandom_range(0, 2) - 1;
         else lb = pick_len();
         if (lb < 0) lb = 0;
         queue_pair(la, lb);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || distance_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Accepted %0d request transactions (%0d wrong-phase or no-op items).",
               accepted_items, noise_items);
      $display("Checked %0d distances, %0d of them with truncation reported.",
               results_checked, overflow_results);
      if (error_count == 0 && distance_expected.size() == 0)
         $display("PASS edit_distance_engine_core");
      else
         $display("FAIL edit_distance_engine_core");
      $finish;
   end

endmodule

/* filelist.f */
hw/rtl/ede_pkg.sv
hw/rtl/ede_cell.sv
hw/rtl/edit_distance_engine_core.sv
tb/edit_distance_engine_core_tb.sv
